[src/wpp_pkg.sv]
// ----------------------------------------------------------------------------
// wpp_pkg
// Shared types and constants of the wave pcm stream parser: request and
// result payloads, status codes, header byte positions and tag bytes.
// ----------------------------------------------------------------------------
package wpp_pkg;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StBadRiff = 3'd1,
    StBadWave = 3'd2,
    StBadFmt  = 3'd3,
    StNotPcm  = 3'd4
  } status_e;

  typedef enum logic {
    KindHeader = 1'b0,
    KindSample = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_t;

  typedef struct packed {
    kind_e              result_kind;
    status_e            status;
    logic [15:0]        channels;
    logic [31:0]        sample_rate;
    logic [15:0]        sample_bits;
    logic [31:0]        data_length;
    logic signed [31:0] sample_value;
    logic [15:0]        channel_index;
    logic               last_sample;
  } out_t;

  // header byte positions
  localparam logic [5:0] HdrLen       = 6'd44;
  localparam logic [5:0] PosRiffEnd   = 6'd4;
  localparam logic [5:0] PosWaveTag   = 6'd8;
  localparam logic [5:0] PosFmtTag    = 6'd12;
  localparam logic [5:0] PosTagEnd    = 6'd16;
  localparam logic [5:0] PosFormatHi  = 6'd21;
  localparam logic [5:0] PosChanHi    = 6'd23;
  localparam logic [5:0] PosRateHi    = 6'd27;
  localparam logic [5:0] PosBitsHi    = 6'd35;

  localparam logic [15:0] FormatPcm   = 16'd1;

  // expected tag bytes for header positions 0..15, size field reads as zero
  function automatic logic [7:0] tag_byte(logic [3:0] pos);
    logic [7:0] t;
    case (pos)
      4'd0:    t = 8'h52;
      4'd1:    t = 8'h49;
      4'd2:    t = 8'h46;
      4'd3:    t = 8'h46;
      4'd8:    t = 8'h57;
      4'd9:    t = 8'h41;
      4'd10:   t = 8'h56;
      4'd11:   t = 8'h45;
      4'd12:   t = 8'h66;
      4'd13:   t = 8'h6D;
      4'd14:   t = 8'h74;
      4'd15:   t = 8'h20;
      default: t = 8'h00;
    endcase
    return t;
  endfunction

endpackage

[src/wav_pcm_stream_parser_top.sv]
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser_top
// Byte-serial RIFF/WAVE PCM parser: header summary, then Q1.31 samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_data_i): one stream byte per
// request, start_of_file set on the first header byte to restart parsing.
// Output channel (out_valid_o / out_ready_i / out_data_o): a header result
// after byte 43 of the header, then one sample result per complete sample
// of 8, 16, 24 or 32 bits, left-justified signed Q1.31, with its channel
// index and a last flag. Bytes that complete nothing give no result.
// Throughput: one byte per cycle while the skid entry is free. Each byte is
// registered, stepped through the parser once the skid entry is free, and
// its result lands in the output register or, if that is full, the skid.
// A two-entry output buffer (output register plus skid) keeps input ready
// high while one result waits; input ready drops only when both are full,
// and then the held byte waits in the input register.
// Reset clears the parser to header byte 0 and empties both stages.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wpp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output wpp_pkg::out_t out_data_o
);

  logic          s1_vld_q;
  wpp_pkg::in_t  s1_q;
  logic          advance;
  logic          res_valid;
  wpp_pkg::out_t res;
  logic          push, pop;

  logic          out_vld_q, skid_vld_q;
  wpp_pkg::out_t out_q, skid_q;

  assign advance    = s1_vld_q && !skid_vld_q;
  assign in_ready_o = !s1_vld_q || advance;
  assign push       = advance && res_valid;
  assign pop        = out_vld_q && out_ready_i;

  wpp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (s1_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_vld_q) begin
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= push;
        end
      end else if (push) begin
        if (!out_vld_q) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      if (!out_vld_q) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[src/wpp_core.sv]
// ----------------------------------------------------------------------------
// wpp_core
// Parser state and the per-byte step: header capture and checks, then
// sample assembly over the data chunk. One byte is consumed per step.
// ----------------------------------------------------------------------------
module wpp_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  wpp_pkg::in_t  item_i,
  output logic          res_valid_o,
  output wpp_pkg::out_t res_o
);

  logic [5:0]       pos_q, pos_d, pos;
  logic             data_q, data_d, data;
  wpp_pkg::status_e hstat_q, hstat_d, hstat;
  logic [31:0]      shift_q, shift_d, shift;
  logic [15:0]      chan_q, chan_d, chan;
  logic [31:0]      rate_q, rate_d, rate;
  logic [15:0]      width_q, width_d, width;
  logic [31:0]      left_q, left_d, left;
  logic [23:0]      asm_q, asm_d, asmb;
  logic [1:0]       bis_q, bis_d, bis;
  logic [15:0]      ccnt_q, ccnt_d, ccnt;

  logic [7:0]       b;
  logic [2:0]       nb;
  logic             width_ok;
  logic [31:0]      val;

  always_comb begin
    // a start mark clears everything before this byte is taken
    if (item_i.start_of_file) begin
      pos   = '0;
      data  = 1'b0;
      hstat = wpp_pkg::StOk;
      shift = '0;
      chan  = '0;
      rate  = '0;
      width = '0;
      left  = '0;
      asmb  = '0;
      bis   = '0;
      ccnt  = '0;
    end else begin
      pos   = pos_q;
      data  = data_q;
      hstat = hstat_q;
      shift = shift_q;
      chan  = chan_q;
      rate  = rate_q;
      width = width_q;
      left  = left_q;
      asmb  = asm_q;
      bis   = bis_q;
      ccnt  = ccnt_q;
    end

    pos_d   = pos;
    data_d  = data;
    hstat_d = hstat;
    shift_d = shift;
    chan_d  = chan;
    rate_d  = rate;
    width_d = width;
    left_d  = left;
    asm_d   = asmb;
    bis_d   = bis;
    ccnt_d  = ccnt;

    b           = item_i.data_byte;
    res_valid_o = 1'b0;
    res_o       = '0;
    nb          = width[5:3];
    width_ok    = 1'b0;
    val         = '0;

    case (width)
      16'd8, 16'd16, 16'd24, 16'd32: width_ok = 1'b1;
      default:                       width_ok = 1'b0;
    endcase

    if (!data) begin
      if (pos < wpp_pkg::HdrLen) begin
        shift_d = {b, shift[31:8]};
        if (pos < wpp_pkg::PosTagEnd
            && (pos < wpp_pkg::PosRiffEnd || pos >= wpp_pkg::PosWaveTag)
            && b != wpp_pkg::tag_byte(pos[3:0]) && hstat == wpp_pkg::StOk) begin
          if (pos < wpp_pkg::PosRiffEnd) begin
            hstat_d = wpp_pkg::StBadRiff;
          end else if (pos < wpp_pkg::PosFmtTag) begin
            hstat_d = wpp_pkg::StBadWave;
          end else begin
            hstat_d = wpp_pkg::StBadFmt;
          end
        end
        if (pos == wpp_pkg::PosFormatHi && shift_d[31:16] != wpp_pkg::FormatPcm
            && hstat == wpp_pkg::StOk) begin
          hstat_d = wpp_pkg::StNotPcm;
        end
        if (pos == wpp_pkg::PosChanHi) begin
          chan_d = shift_d[31:16];
        end
        if (pos == wpp_pkg::PosRateHi) begin
          rate_d = shift_d;
        end
        if (pos == wpp_pkg::PosBitsHi) begin
          width_d = shift_d[31:16];
        end
        pos_d = pos + 6'd1;
        if (pos == wpp_pkg::HdrLen - 6'd1) begin
          left_d                = shift_d;
          data_d                = (hstat_d == wpp_pkg::StOk);
          asm_d                 = '0;
          bis_d                 = '0;
          ccnt_d                = '0;
          res_valid_o           = 1'b1;
          res_o.result_kind     = wpp_pkg::KindHeader;
          res_o.status          = hstat_d;
          res_o.channels        = chan_d;
          res_o.sample_rate     = rate_d;
          res_o.sample_bits     = width_d;
          res_o.data_length     = shift_d;
        end
      end
    end else if (left != 32'd0) begin
      left_d = left - 32'd1;
      if (width_ok) begin
        if ({1'b0, bis} + 3'd1 < nb) begin
          case (bis)
            2'd0:    asm_d[7:0]   = b;
            2'd1:    asm_d[15:8]  = b;
            default: asm_d[23:16] = b;
          endcase
          bis_d = bis + 2'd1;
        end else begin
          // left-justify; 8-bit data is offset binary
          case (nb)
            3'd1:    val = {~b[7], b[6:0], 24'd0};
            3'd2:    val = {b, asmb[7:0], 16'd0};
            3'd3:    val = {b, asmb[15:0], 8'd0};
            default: val = {b, asmb[23:0]};
          endcase
          asm_d               = '0;
          bis_d               = '0;
          res_valid_o         = 1'b1;
          res_o.result_kind   = wpp_pkg::KindSample;
          res_o.sample_value  = val;
          res_o.channel_index = ccnt;
          res_o.last_sample   = (left_d < {29'd0, nb});
          if ({1'b0, ccnt} + 17'd1 >= {1'b0, chan}) begin
            ccnt_d = '0;
          end else begin
            ccnt_d = ccnt + 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      data_q  <= 1'b0;
      hstat_q <= wpp_pkg::StOk;
      shift_q <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      width_q <= '0;
      left_q  <= '0;
      asm_q   <= '0;
      bis_q   <= '0;
      ccnt_q  <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      data_q  <= data_d;
      hstat_q <= hstat_d;
      shift_q <= shift_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      width_q <= width_d;
      left_q  <= left_d;
      asm_q   <= asm_d;
      bis_q   <= bis_d;
      ccnt_q  <= ccnt_d;
    end
  end

endmodule

[tb/wav_pcm_stream_parser_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser_top_test
// Streams canonical RIFF/WAVE files byte by byte into the parser: directed
// files for tag errors, format codes, every sample width and its extremes,
// truncation and restarts, then random files and noise. Each accepted byte
// steps a behavioral parser in the scoreboard, which queues the header and
// sample results and checks every result field in order.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser_top_test;

  // riff, wave and fmt tags at header bytes 0..15, lowest byte first
  localparam logic [127:0] TagBytes = {8'h20, 8'h74, 8'h6D, 8'h66,
                                       8'h45, 8'h56, 8'h41, 8'h57,
                                       32'h0,
                                       8'h46, 8'h46, 8'h49, 8'h52};
  localparam int CycleLimit = 200000;
  localparam int RandomBytes = 150;

  typedef logic [7:0] byte_q_t[$];

  class wav_parse_scoreboard;
    logic [5:0]       hdr_pos;
    logic             data_phase;
    wpp_pkg::status_e hdr_status;
    logic [31:0]      shift_reg;
    logic [15:0]      chan_count;
    logic [31:0]      rate;
    logic [15:0]      bits;
    logic [31:0]      bytes_left;
    logic [23:0]      partial;
    logic [1:0]       byte_idx;
    logic [15:0]      chan_idx;
    wpp_pkg::out_t    parsed_results_q[$];
    int               errors;

    function new();
      errors = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      hdr_pos    = '0;
      data_phase = 1'b0;
      hdr_status = wpp_pkg::StOk;
      shift_reg  = '0;
      chan_count = '0;
      rate       = '0;
      bits       = '0;
      bytes_left = '0;
      partial    = '0;
      byte_idx   = '0;
      chan_idx   = '0;
    endfunction

    // step the parser with one accepted request and queue what it yields
    function void take_stream_byte(wpp_pkg::in_t req);
      wpp_pkg::out_t res;
      logic [7:0]    b;
      int            p;
      int unsigned   nb;
      int unsigned   k;
      logic [31:0]   raw;
      b   = req.data_byte;
      res = '0;
      if (req.start_of_file) clear_parser();
      if (!data_phase) begin
        p = int'(hdr_pos);
        if (p >= 44) return;
        shift_reg = {b, shift_reg[31:8]};
        if (p < 16 && (p < 4 || p >= 8) && b != TagBytes[p*8 +: 8]
            && hdr_status == wpp_pkg::StOk) begin
          hdr_status = (p < 4) ? wpp_pkg::StBadRiff :
                       (p < 12) ? wpp_pkg::StBadWave : wpp_pkg::StBadFmt;
        end
        if (p == 21 && shift_reg[31:16] != 16'd1 && hdr_status == wpp_pkg::StOk) begin
          hdr_status = wpp_pkg::StNotPcm;
        end
        if (p == 23) chan_count = shift_reg[31:16];
        if (p == 27) rate = shift_reg;
        if (p == 35) bits = shift_reg[31:16];
        hdr_pos = hdr_pos + 6'd1;
        if (p != 43) return;
        bytes_left = shift_reg;
        data_phase = (hdr_status == wpp_pkg::StOk);
        partial    = '0;
        byte_idx   = '0;
        chan_idx   = '0;
        res.result_kind = wpp_pkg::KindHeader;
        res.status      = hdr_status;
        res.channels    = chan_count;
        res.sample_rate = rate;
        res.sample_bits = bits;
        res.data_length = bytes_left;
        parsed_results_q.push_back(res);
      end else begin
        if (bytes_left == 0) return;
        bytes_left = bytes_left - 32'd1;
        if (bits != 16'd8 && bits != 16'd16 && bits != 16'd24 && bits != 16'd32) return;
        nb = 32'(bits >> 3);
        k  = 32'(byte_idx);
        if (k + 1 < nb) begin
          partial  = partial | (24'(b) << (8 * k));
          byte_idx = byte_idx + 2'd1;
          return;
        end
        raw = {8'h00, partial} | (32'(b) << (8 * (nb - 1)));
        // 8-bit wave data is offset binary
        if (nb == 1) raw[7] = ~raw[7];
        partial  = '0;
        byte_idx = '0;
        res.result_kind   = wpp_pkg::KindSample;
        res.status        = wpp_pkg::StOk;
        res.sample_value  = raw << (32 - 8 * nb);
        res.channel_index = chan_idx;
        res.last_sample   = (bytes_left < nb);
        if ({16'd0, chan_idx} + 32'd1 >= {16'd0, chan_count}) chan_idx = '0;
        else chan_idx = chan_idx + 16'd1;
        parsed_results_q.push_back(res);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_parsed_result(wpp_pkg::out_t got);
      wpp_pkg::out_t want;
      if (parsed_results_q.size() == 0) begin
        $error("result with nothing pending: %h", got);
        errors++;
        return;
      end
      want = parsed_results_q.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("status", want.status, got.status);
      compare_field("channels", want.channels, got.channels);
      compare_field("sample_rate", want.sample_rate, got.sample_rate);
      compare_field("sample_bits", want.sample_bits, got.sample_bits);
      compare_field("data_length", want.data_length, got.data_length);
      compare_field("sample_value", want.sample_value, got.sample_value);
      compare_field("channel_index", want.channel_index, got.channel_index);
      compare_field("last_sample", want.last_sample, got.last_sample);
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid;
  logic          in_ready;
  wpp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  wpp_pkg::out_t out_data;

  logic  in_gaps;
  logic  out_stalls;
  int    bytes_sent;
  int    cycles;
  wav_parse_scoreboard sb;

  wav_pcm_stream_parser_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(logic sof, logic [7:0] b);
    wpp_pkg::in_t req;
    req.data_byte     = b;
    req.start_of_file = sof;
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.take_stream_byte(req);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic byte_q_t random_bytes(int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // one wave file: 44-byte header then the given data bytes
  task automatic send_file(logic sof, logic [15:0] fmt_code, logic [15:0] chans,
                           logic [31:0] rate, logic [15:0] bits, logic [31:0] dlen,
                           logic [15:0] tag_flips, byte_q_t payload);
    logic [7:0] hdr[44];
    int i;
    for (i = 0; i < 44; i++) hdr[i] = 8'($urandom_range(0, 255));
    for (i = 0; i < 16; i++) begin
      if (i < 4 || i >= 8) hdr[i] = TagBytes[i*8 +: 8];
    end
    {hdr[21], hdr[20]} = fmt_code;
    {hdr[23], hdr[22]} = chans;
    {hdr[27], hdr[26], hdr[25], hdr[24]} = rate;
    {hdr[35], hdr[34]} = bits;
    {hdr[39], hdr[38], hdr[37], hdr[36]} = 32'h61746164;
    {hdr[43], hdr[42], hdr[41], hdr[40]} = dlen;
    for (i = 0; i < 16; i++) begin
      if (tag_flips[i]) hdr[i] = hdr[i] ^ 8'($urandom_range(1, 255));
    end
    for (i = 0; i < 44; i++) send_request(sof && i == 0, hdr[i]);
    foreach (payload[j]) send_request(1'b0, payload[j]);
  endtask

  // receiver with random stall bursts
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (out_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(0, 10);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (rst_ni && out_valid && out_ready) sb.check_parsed_result(out_data);
    end
  end

  initial begin
    int          rand_start;
    int          sel;
    int          n;
    int          guard;
    logic [15:0] bits;
    logic [15:0] chans;
    logic [15:0] flips;
    logic [15:0] fmt_code;
    logic [31:0] dlen;
    byte_q_t     payload;

    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
    bytes_sent = 0;
    sb = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // no start mark after reset, 8-bit extremes, bytes past the data chunk
    send_file(1'b0, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd5, 16'h0,
              '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h12, 8'h34, 8'h56});
    // 16-bit stereo with a trailing partial sample
    send_file(1'b1, 16'd1, 16'd2, 32'd44100, 16'd16, 32'd9, 16'h0,
              '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hAA});
    send_file(1'b1, 16'd1, 16'd3, 32'd48000, 16'd24, 32'd12, 16'h0,
              '{8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h7F,
                8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF});
    // zero channels keeps the channel index at zero
    send_file(1'b1, 16'd1, 16'd0, 32'd96000, 16'd32, 32'd16, 16'h0,
              '{8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    // unsupported width counts data down without samples
    send_file(1'b1, 16'd1, 16'd1, 32'd8000, 16'd12, 32'd4, 16'h0, random_bytes(6));
    // riff and wave both broken: first error wins
    send_file(1'b1, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd4, 16'h0202, random_bytes(4));
    send_file(1'b1, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd4, 16'h0400, random_bytes(4));
    send_file(1'b1, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd4, 16'h4000, random_bytes(4));
    send_file(1'b1, 16'd3, 16'd1, 32'd8000, 16'd8, 32'd4, 16'h0, random_bytes(4));
    send_file(1'b1, 16'hFFFF, 16'd1, 32'd8000, 16'd8, 32'd4, 16'h1000, random_bytes(2));
    // huge data chunk cut short by a start mark
    send_file(1'b1, 16'd1, 16'hFFFF, 32'hFFFF_FFFF, 16'd16, 32'hFFFF_FFFF, 16'h0,
              random_bytes(7));
    send_file(1'b1, 16'd1, 16'd1, 32'd0, 16'd8, 32'd0, 16'h0, random_bytes(2));
    send_file(1'b1, 16'd1, 16'd2, 32'd0, 16'hFFFF, 32'd3, 16'h0, random_bytes(3));

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RandomBytes) begin
      if (bytes_sent - rand_start >= RandomBytes - 100) begin
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
      end else begin
        in_gaps    = ($urandom_range(0, 3) != 0);
        out_stalls = ($urandom_range(0, 3) != 0);
      end
      sel = $urandom_range(0, 9);
      if (sel <= 7) begin
        case ($urandom_range(0, 9))
          0, 1:    bits = 16'd8;
          2, 3:    bits = 16'd16;
          4, 5:    bits = 16'd24;
          6, 7:    bits = 16'd32;
          8:       bits = 16'($urandom);
          default: bits = 16'($urandom_range(0, 40));
        endcase
        chans = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        n = $urandom_range(0, 24);
        case ($urandom_range(0, 5))
          0:       dlen = $urandom;
          1:       dlen = $urandom_range(0, n);
          default: dlen = n;
        endcase
        fmt_code = 16'd1;
        flips    = '0;
        // a broken header now and then
        if (sel == 7) begin
          if ($urandom_range(0, 1) == 0) flips = 16'd1 << $urandom_range(0, 15);
          else fmt_code = 16'($urandom);
        end
        send_file(1'b1, fmt_code, chans, $urandom, bits, dlen, flips, random_bytes(n));
      end else begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
          send_request((i == 0 && sel == 9) || $urandom_range(0, 9) == 0,
                       8'($urandom_range(0, 255)));
        end
      end
    end
    in_valid <= 1'b0;

    guard = 0;
    while (sb.parsed_results_q.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.parsed_results_q.size() != 0) begin
      $error("%0d results never arrived", sb.parsed_results_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
